// ----- src/ftcc_pkg.sv -----
package ftcc_pkg;

  // Geometry field widths, fixed by the register map
  localparam int unsigned TAG_BITS    = 64;
  localparam int unsigned DIM_BITS    = 4;
  localparam int unsigned BORDER_BITS = 3;
  localparam int unsigned RING_BITS   = BORDER_BITS + 1;
  // Widest edge is 15 + 2 * (7 + 7) = 43
  localparam int unsigned EDGE_BITS   = 6;
  localparam int unsigned AREA_BITS   = 2 * DIM_BITS;
  localparam int unsigned TAG_IDX_BITS = 6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAG_CODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAYLOAD_DIM  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLACK_BORDER = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_BORDER = 2'd3;

  // Reset values
  localparam logic [DIM_BITS-1:0]    PAYLOAD_DIM_RST  = 4'd6;
  localparam logic [BORDER_BITS-1:0] BLACK_BORDER_RST = 3'd1;
  localparam logic [BORDER_BITS-1:0] WHITE_BORDER_RST = 3'd1;

  // Result packing
  localparam int unsigned CODE_BITS    = 8;
  localparam int unsigned RESULT_BITS  = 1 + 1 + CODE_BITS + 1;
  localparam int unsigned OUT_TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;

  // Window pixel weights in the low nibble
  localparam logic [3:0] WIN_TL = 4'h4;
  localparam logic [3:0] WIN_TR = 4'h8;
  localparam logic [3:0] WIN_BL = 4'h2;
  localparam logic [3:0] WIN_BR = 4'h1;

  // Corner kinds for the high nibble
  localparam logic [3:0] KIND_FLAT    = 4'h0;
  localparam logic [3:0] KIND_EDGE    = 4'h1;
  localparam logic [3:0] KIND_IN_BLK  = 4'h2;
  localparam logic [3:0] KIND_IN_WHT  = 4'h4;
  localparam logic [3:0] KIND_CHECKER = 4'h8;

  // Window kind indexed by the packed four pixels
  localparam logic [3:0] CORNER_KIND [16] = '{
    KIND_FLAT,   KIND_IN_BLK,  KIND_IN_BLK,  KIND_EDGE,
    KIND_IN_BLK, KIND_CHECKER, KIND_EDGE,    KIND_IN_WHT,
    KIND_IN_BLK, KIND_EDGE,    KIND_CHECKER, KIND_IN_WHT,
    KIND_EDGE,   KIND_IN_WHT,  KIND_IN_WHT,  KIND_FLAT
  };

  // Raster geometry derived from the registers
  typedef struct packed {
    logic [TAG_BITS-1:0]    tag_code;
    logic [DIM_BITS-1:0]    dim;
    logic [AREA_BITS-1:0]   area;
    logic [BORDER_BITS-1:0] white;
    logic [RING_BITS-1:0]   ring;
    logic [EDGE_BITS-1:0]   edge_len;
    logic [EDGE_BITS-1:0]   edge_white;
    logic [EDGE_BITS-1:0]   edge_ring;
  } geom_t;

endpackage

// ----- src/ftcc_pixel.sv -----
// One raster pixel lookup, 1 white, 0 black, 0 outside the raster
module ftcc_pixel #(
  parameter int unsigned CW = 8
) (
  input  ftcc_pkg::geom_t  geom,
  input  logic [CW-1:0]    px,
  input  logic [CW-1:0]    py,
  output logic             value
);
  import ftcc_pkg::*;

  logic [CW-1:0]           edge_w, white_w, ring_w, edge_white_w, edge_ring_w;
  logic                    outside, in_white, in_black;
  logic [DIM_BITS-1:0]     dx, dy;
  logic [AREA_BITS-1:0]    cell_no, idx;
  logic [CW-1:0]           ox, oy;

  assign edge_w       = CW'(geom.edge_len);
  assign white_w      = CW'(geom.white);
  assign ring_w       = CW'(geom.ring);
  assign edge_white_w = CW'(geom.edge_white);
  assign edge_ring_w  = CW'(geom.edge_ring);

  // Ring classification
  assign outside  = (px >= edge_w) || (py >= edge_w);
  assign in_white = (py < white_w) || (py >= edge_white_w) ||
                    (px < white_w) || (px >= edge_white_w);
  assign in_black = (py < ring_w) || (py >= edge_ring_w) ||
                    (px < ring_w) || (px >= edge_ring_w);

  // Payload cell offset, below dim once inside the payload
  assign ox      = px - ring_w;
  assign oy      = py - ring_w;
  assign dx      = ox[DIM_BITS-1:0];
  assign dy      = oy[DIM_BITS-1:0];
  assign cell_no = AREA_BITS'(dx) + AREA_BITS'(geom.dim) * AREA_BITS'(dy);
  assign idx     = geom.area - cell_no - AREA_BITS'(1);

  always_comb begin
    if (outside) begin
      value = 1'b0;
    end else if (in_white) begin
      value = 1'b1;
    end else if (in_black) begin
      value = 1'b0;
    end else if (idx[AREA_BITS-1:TAG_IDX_BITS] != '0) begin
      // bit index beyond the code reads black
      value = 1'b0;
    end else begin
      value = geom.tag_code[idx[TAG_IDX_BITS-1:0]];
    end
  end

endmodule

// ----- src/fiducial_tag_corner_classifier_unit.sv -----
// Fiducial tag corner classifier. For each request (pos_x, pos_y) the block
// returns the tag raster pixel there and the corner code of the 2x2 window
// whose top-left pixel is (pos_x, pos_y). The raster is payload_dim +
// 2*(black_border + white_border) pixels wide: an outer white ring, a black
// ring, then the payload read row by row from tag_code, its highest used bit
// at the top-left cell. Coordinates off the raster give zero data with the
// valid flags cleared. One request is taken every clock while the result
// side is not stalled, with no stall of its own; a request enters an input
// register, the four pixel lookups and the corner table sit between that and
// the result register, so each result passes the input register and then
// the result register before m_tvalid rises. Configuration writes are taken
// at any time but must only be issued while no request is in flight.
module fiducial_tag_corner_classifier_unit #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // s_tdata: pos_x, pos_y, zero pad
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_tdata,
  // m_tdata: pixel_value, pixel_valid, corner_code[7:0], corner_valid, zero pad
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  output logic [ftcc_pkg::OUT_TDATA_W-1:0]              m_tdata,
  // configuration writes
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [ftcc_pkg::CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [ftcc_pkg::TAG_BITS-1:0]                 cfg_data
);
  import ftcc_pkg::*;

  // Room for coordinate plus one and for the edge length
  localparam int unsigned CW = COORD_BITS + 2;

  // Configuration registers
  logic [TAG_BITS-1:0]    tag_code;
  logic [DIM_BITS-1:0]    payload_dim;
  logic [BORDER_BITS-1:0] black_border;
  logic [BORDER_BITS-1:0] white_border;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_code     <= '0;
      payload_dim  <= PAYLOAD_DIM_RST;
      black_border <= BLACK_BORDER_RST;
      white_border <= WHITE_BORDER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAG_CODE:     tag_code     <= cfg_data;
        REG_PAYLOAD_DIM:  payload_dim  <= cfg_data[DIM_BITS-1:0];
        REG_BLACK_BORDER: black_border <= cfg_data[BORDER_BITS-1:0];
        REG_WHITE_BORDER: white_border <= cfg_data[BORDER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Raster geometry
  geom_t geom;
  always_comb begin
    geom.tag_code   = tag_code;
    geom.dim        = payload_dim;
    geom.area       = AREA_BITS'(payload_dim) * AREA_BITS'(payload_dim);
    geom.white      = white_border;
    geom.ring       = RING_BITS'(black_border) + RING_BITS'(white_border);
    geom.edge_len   = EDGE_BITS'(payload_dim) + EDGE_BITS'({geom.ring, 1'b0});
    geom.edge_white = geom.edge_len - EDGE_BITS'(white_border);
    geom.edge_ring  = geom.edge_len - EDGE_BITS'(geom.ring);
  end

  // Pipeline control: both stages move when the result register frees up; an empty input register also takes a request
  logic in_valid;
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register
  logic [COORD_BITS-1:0] in_x, in_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_x <= s_tdata[COORD_BITS-1:0];
      in_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  // Window coordinates
  logic [CW-1:0] x0, y0, x1, y1, edge_w;
  assign x0     = CW'(in_x);
  assign y0     = CW'(in_y);
  assign x1     = x0 + CW'(1);
  assign y1     = y0 + CW'(1);
  assign edge_w = CW'(geom.edge_len);

  logic p_tl, p_tr, p_bl, p_br;

  ftcc_pixel #(.CW(CW)) u_pix_tl (.geom(geom), .px(x0), .py(y0), .value(p_tl));
  ftcc_pixel #(.CW(CW)) u_pix_tr (.geom(geom), .px(x1), .py(y0), .value(p_tr));
  ftcc_pixel #(.CW(CW)) u_pix_bl (.geom(geom), .px(x0), .py(y1), .value(p_bl));
  ftcc_pixel #(.CW(CW)) u_pix_br (.geom(geom), .px(x1), .py(y1), .value(p_br));

  // Validity flags and corner code
  logic                 pix_valid, win_valid;
  logic [3:0]           win_bits;
  logic [CODE_BITS-1:0] code;

  assign pix_valid = (x0 < edge_w) && (y0 < edge_w);
  assign win_valid = (x1 < edge_w) && (y1 < edge_w);
  assign win_bits  = (p_tl ? WIN_TL : 4'h0) | (p_tr ? WIN_TR : 4'h0) |
                     (p_bl ? WIN_BL : 4'h0) | (p_br ? WIN_BR : 4'h0);
  assign code      = win_valid ? {CORNER_KIND[win_bits], win_bits} : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {{(OUT_TDATA_W-RESULT_BITS){1'b0}}, win_valid, code, pix_valid, p_tl};
    end
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftcc_pkg::*;

  localparam int COORD_W      = 6;
  localparam int IN_W         = ((2 * COORD_W + 7) / 8) * 8;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 40;

  // Traffic shapes for the random phases
  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SRC_IDLE,
    TRAFFIC_SINK_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  // Expected answer for one coordinate request
  typedef struct {
    logic       value;
    logic       pvalid;
    logic [7:0] code;
    logic       cvalid;
  } pixel_answer_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_W-1:0]         s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [TAG_BITS-1:0]     cfg_data;

  // Local copy of the register file
  logic [TAG_BITS-1:0]    cur_tag;
  logic [DIM_BITS-1:0]    cur_dim;
  logic [BORDER_BITS-1:0] cur_black;
  logic [BORDER_BITS-1:0] cur_white;

  pixel_answer_t answer_q[$];
  int            fail_count;
  int            idle_cycles;
  int            src_idle_pct;
  int            sink_stall_pct;
  logic [COORD_W-1:0] scan_x;
  logic [COORD_W-1:0] scan_y;

  fiducial_tag_corner_classifier_unit #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Raster prediction
  // ---------------------------------------------------------------------

  function automatic int raster_span();
    return int'(cur_dim) + 2 * (int'(cur_black) + int'(cur_white));
  endfunction

  // Pixel of the tag raster, black off the raster
  function automatic logic raster_bit(int x, int y);
    int span;
    int ring;
    int wht;
    int dim;
    int cell_no;
    int bit_idx;
    span = raster_span();
    wht  = int'(cur_white);
    ring = int'(cur_black) + wht;
    dim  = int'(cur_dim);
    if (x >= span || y >= span) return 1'b0;
    // outer white ring
    if (y < wht || y >= span - wht || x < wht || x >= span - wht) return 1'b1;
    // black ring
    if (y < ring || y >= span - ring || x < ring || x >= span - ring) return 1'b0;
    // payload, top-left cell takes the highest used bit
    cell_no = (x - ring) + dim * (y - ring);
    bit_idx = dim * dim - cell_no - 1;
    if (bit_idx >= TAG_BITS) return 1'b0;
    return cur_tag[bit_idx];
  endfunction

  // Kind of a 2x2 window from how many pixels are white and where
  function automatic logic [3:0] window_kind(logic [3:0] win);
    case ($countones(win))
      1: return KIND_IN_BLK;
      3: return KIND_IN_WHT;
      2: begin
        if (win == (WIN_TL | WIN_BR) || win == (WIN_TR | WIN_BL)) return KIND_CHECKER;
        return KIND_EDGE;
      end
      default: return KIND_FLAT;
    endcase
  endfunction

  function automatic pixel_answer_t classify_pixel(int x, int y);
    pixel_answer_t ans;
    logic [3:0]    win;
    int            span;
    span       = raster_span();
    ans.pvalid = (x < span) && (y < span);
    ans.value  = ans.pvalid ? raster_bit(x, y) : 1'b0;
    ans.cvalid = (x + 1 < span) && (y + 1 < span);
    ans.code   = '0;
    if (ans.cvalid) begin
      win = '0;
      if (raster_bit(x, y))         win |= WIN_TL;
      if (raster_bit(x + 1, y))     win |= WIN_TR;
      if (raster_bit(x, y + 1))     win |= WIN_BL;
      if (raster_bit(x + 1, y + 1)) win |= WIN_BR;
      ans.code = {window_kind(win), win};
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  function automatic void report_fail(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_result
    pixel_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (answer_q.size() == 0) begin
        report_fail($sformatf("unexpected result m_tdata=%h", m_tdata));
      end else begin
        want = answer_q.pop_front();
        if (m_tdata[0] !== want.value)
          report_fail($sformatf("pixel_value: expected %b, got %b", want.value, m_tdata[0]));
        if (m_tdata[1] !== want.pvalid)
          report_fail($sformatf("pixel_valid: expected %b, got %b", want.pvalid, m_tdata[1]));
        if (m_tdata[9:2] !== want.code)
          report_fail($sformatf("corner_code: expected %h, got %h", want.code, m_tdata[9:2]));
        if (m_tdata[10] !== want.cvalid)
          report_fail($sformatf("corner_valid: expected %b, got %b", want.cvalid, m_tdata[10]));
      end
    end
  end

  // Watchdog: give up once nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  function automatic void set_traffic(traffic_t mode);
    case (mode)
      TRAFFIC_SRC_IDLE:   begin src_idle_pct = 53; sink_stall_pct = 0;  end
      TRAFFIC_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 53; end
      TRAFFIC_BOTH:       begin src_idle_pct = 24; sink_stall_pct = 24; end
      default:            begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endfunction

  // One coordinate request; predicts the answer on acceptance
  task automatic send_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 2 * COORD_W){1'b0}}, y, x};
    do @(posedge clk); while (!s_tready);
    answer_q.push_back(classify_pixel(int'(x), int'(y)));
    @(negedge clk);
  endtask

  // Stop requests and let every outstanding answer come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (answer_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TAG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TAG_CODE:     cur_tag   = data;
      REG_PAYLOAD_DIM:  cur_dim   = data[DIM_BITS-1:0];
      REG_BLACK_BORDER: cur_black = data[BORDER_BITS-1:0];
      REG_WHITE_BORDER: cur_white = data[BORDER_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Full geometry update; upper data bits of the narrow registers carry noise
  task automatic load_geometry(logic [TAG_BITS-1:0] tag, logic [DIM_BITS-1:0] dim,
                               logic [BORDER_BITS-1:0] blk, logic [BORDER_BITS-1:0] wht);
    logic [TAG_BITS-1:0] noise;
    wait_drained();
    noise = {$urandom, $urandom};
    write_reg(REG_TAG_CODE, tag);
    write_reg(REG_PAYLOAD_DIM, {noise[TAG_BITS-1:DIM_BITS], dim});
    write_reg(REG_BLACK_BORDER, {noise[TAG_BITS-1:BORDER_BITS], blk});
    write_reg(REG_WHITE_BORDER, {~noise[TAG_BITS-1:BORDER_BITS], wht});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset geometry: 6x6 payload, one-pixel rings, all-black payload
  task automatic test_reset_geometry();
    set_traffic(TRAFFIC_FREE);
    send_coord(6'd0, 6'd0);
    send_coord(6'd63, 6'd63);
    send_coord(6'd9, 6'd0);
    send_coord(6'd8, 6'd8);
    send_coord(6'd4, 6'd4);
    send_coord(6'd0, 6'd9);
  endtask

  // Extreme geometries and window kinds
  task automatic test_directed_geometry();
    set_traffic(TRAFFIC_FREE);
    // full 8x8 white payload with no rings
    load_geometry('1, 4'd8, 3'd0, 3'd0);
    send_coord(6'd0, 6'd0);
    send_coord(6'd7, 6'd7);
    send_coord(6'd6, 6'd6);
    send_coord(6'd3, 6'd5);
    // checkerboard payload: checker windows inside, inner corners at the rings
    load_geometry(64'hAA55_AA55_AA55_AA55, 4'd8, 3'd1, 3'd2);
    send_coord(6'd3, 6'd3);
    send_coord(6'd4, 6'd3);
    send_coord(6'd3, 6'd4);
    send_coord(6'd2, 6'd2);
    send_coord(6'd1, 6'd1);
    send_coord(6'd12, 6'd12);
    send_coord(6'd13, 6'd13);
    // empty raster: nothing is valid
    load_geometry('1, 4'd0, 3'd0, 3'd0);
    send_coord(6'd0, 6'd0);
    send_coord(6'd63, 6'd0);
    // oversized payload: cells past the tag width read black
    load_geometry('1, 4'd15, 3'd7, 3'd7);
    send_coord(6'd14, 6'd14);
    send_coord(6'd41, 6'd41);
    send_coord(6'd42, 6'd42);
    send_coord(6'd28, 6'd28);
    send_coord(6'd41, 6'd0);
  endtask

  // Random geometries, mostly on-raster coordinates with some raster scans
  task automatic test_random_rasters();
    logic [TAG_BITS-1:0]    tag;
    logic [DIM_BITS-1:0]    dim;
    logic [BORDER_BITS-1:0] blk;
    logic [BORDER_BITS-1:0] wht;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    int                     lim;
    int                     pick;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      pick = $urandom_range(9);
      tag  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick < 7) dim = DIM_BITS'($urandom_range(8, 1));
      else if (pick == 7) dim = 4'd0;
      else dim = DIM_BITS'($urandom_range(15, 9));
      blk = BORDER_BITS'($urandom_range(7));
      wht = BORDER_BITS'($urandom_range(7));
      // first phases pin the border extremes
      if (phase == 0) begin blk = 3'd0; wht = 3'd7; end
      if (phase == 1) begin blk = 3'd7; wht = 3'd0; end
      load_geometry(tag, dim, blk, wht);
      set_traffic(traffic_t'(phase % 4));
      lim    = raster_span() + 1;
      if (lim > 63) lim = 63;
      scan_x = '0;
      scan_y = COORD_W'($urandom_range(lim));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          x = COORD_W'($urandom_range(lim));
          y = COORD_W'($urandom_range(lim));
        end else if (pick < 8) begin
          // walk along a raster row
          if (int'(scan_x) >= lim) begin
            scan_x = '0;
            scan_y = (int'(scan_y) >= lim) ? '0 : scan_y + 1'b1;
          end else begin
            scan_x = scan_x + 1'b1;
          end
          x = scan_x;
          y = scan_y;
        end else begin
          x = COORD_W'($urandom_range(63));
          y = COORD_W'($urandom_range(63));
        end
        send_coord(x, y);
        // source holds off once until the pipe is empty
        if (phase == 5 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_TAG_CODE;
    cfg_data       = '0;
    fail_count     = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    scan_x         = '0;
    scan_y         = '0;
    cur_tag        = '0;
    cur_dim        = PAYLOAD_DIM_RST;
    cur_black      = BLACK_BORDER_RST;
    cur_white      = WHITE_BORDER_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_geometry();
    test_directed_geometry();
    test_random_rasters();

    // let the last answers drain; the watchdog bounds this wait
    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
